FILE: hdl/gbn_arq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_arq_pkg
// shared constants, codes and types of the go-back-n link endpoint
// ----------------------------------------------------------------------------
package gbn_arq_pkg;

  // sequence space: numbers 0 .. SEQ_MAX, arithmetic modulo SEQ_MAX + 1
  localparam int SEQ_MAX      = 7;
  localparam int MODULUS      = SEQ_MAX + 1;
  localparam int SEQ_BITS     = 3;
  localparam int PAYLOAD_BITS = 32;

  // event codes
  localparam logic [1:0] CMD_NET_READY = 2'd0;
  localparam logic [1:0] CMD_FRAME     = 2'd1;
  localparam logic [1:0] CMD_TIMEOUT   = 2'd2;
  localparam logic [1:0] CMD_CKSUM_ERR = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_STATUS  = 2'd0;
  localparam logic [1:0] KIND_DATA    = 2'd1;
  localparam logic [1:0] KIND_NAK     = 2'd2;
  localparam logic [1:0] KIND_DELIVER = 2'd3;

  typedef struct packed {
    logic [1:0]              command;
    logic [PAYLOAD_BITS-1:0] tx_payload;
    logic                    rx_valid;
    logic [SEQ_BITS-1:0]     rx_seq;
    logic [SEQ_BITS-1:0]     rx_ack;
    logic [PAYLOAD_BITS-1:0] rx_payload;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic [SEQ_BITS-1:0]     frame_seq;
    logic [SEQ_BITS-1:0]     frame_ack;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [SEQ_BITS-1:0]     outstanding;
    logic                    network_enabled;
    logic                    last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic capture;       // latch the accepted item
    logic exec_single;   // produce the one result of a non-resend event
    logic start_resend;  // load the resend pointer and read the oldest frame
    logic emit_resend;   // push one resent frame, read the next one
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;       // output register may be loaded this cycle
    logic resend_needed;  // timeout with frames outstanding
    logic resend_last;    // the frame on hand is the last to resend
  } dp_status_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_EXEC   = 3'b010,
    S_RESEND = 3'b100
  } state_e;

endpackage
`default_nettype wire

FILE: hdl/gbn_arq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_arq_ctrl
// sequencer: accept, execute, and step through a timeout resend
// ----------------------------------------------------------------------------
module gbn_arq_ctrl (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire gbn_arq_pkg::dp_status_t status_i,
  output gbn_arq_pkg::dp_cmd_t         cmd_o
);

  gbn_arq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gbn_arq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      gbn_arq_pkg::S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = gbn_arq_pkg::S_EXEC;
        end
      end
      gbn_arq_pkg::S_EXEC: begin
        if (status_i.resend_needed) begin
          cmd_o.start_resend = 1'b1;
          state_d            = gbn_arq_pkg::S_RESEND;
        end else if (status_i.out_free) begin
          cmd_o.exec_single = 1'b1;
          state_d           = gbn_arq_pkg::S_IDLE;
        end
      end
      gbn_arq_pkg::S_RESEND: begin
        if (status_i.out_free) begin
          cmd_o.emit_resend = 1'b1;
          if (status_i.resend_last) begin
            state_d = gbn_arq_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_d = gbn_arq_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/gbn_arq_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_arq_dp
// window state, packet store, resend counter and output register
// ----------------------------------------------------------------------------
module gbn_arq_dp (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire gbn_arq_pkg::in_item_t   in_item_i,
  input  wire gbn_arq_pkg::dp_cmd_t    cmd_i,
  output gbn_arq_pkg::dp_status_t      status_o,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output gbn_arq_pkg::out_item_t       out_item_o
);

  localparam int SB = gbn_arq_pkg::SEQ_BITS;
  localparam int PB = gbn_arq_pkg::PAYLOAD_BITS;
  localparam logic [SB-1:0] SEQ_TOP = SB'(gbn_arq_pkg::SEQ_MAX);
  localparam logic [SB:0]   MOD_W   = (SB+1)'(gbn_arq_pkg::MODULUS);

  function automatic logic [SB-1:0] seq_inc(input logic [SB-1:0] s);
    return (s == SEQ_TOP) ? '0 : s + 1'b1;
  endfunction

  // forward distance from a to b
  function automatic logic [SB-1:0] seq_dist(input logic [SB-1:0] a, input logic [SB-1:0] b);
    logic [SB:0] t;
    if (b >= a) begin
      t = {1'b0, b} - {1'b0, a};
    end else begin
      t = {1'b0, b} + MOD_W - {1'b0, a};
    end
    return t[SB-1:0];
  endfunction

  // b lies in the circular span [a, c)
  function automatic logic in_span(input logic [SB-1:0] a, input logic [SB-1:0] b,
                                   input logic [SB-1:0] c);
    return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
  endfunction

  function automatic logic [SB-1:0] ack_of(input logic [SB-1:0] e);
    return (e == '0) ? SEQ_TOP : e - 1'b1;
  endfunction

  gbn_arq_pkg::in_item_t  in_q;
  gbn_arq_pkg::out_item_t out_q, single_res, resend_res;
  logic                   out_valid_q;

  logic [SB-1:0] next_q, next_d;
  logic [SB-1:0] oldest_q, oldest_d;
  logic [SB-1:0] expected_q, expected_d;
  logic [SB-1:0] count_q, count_d;
  logic [SB-1:0] rd_ptr_q;
  logic [SB-1:0] left_q;
  logic [SB-1:0] rd_addr;
  logic [PB-1:0] rd_data_q;
  logic          store_we;
  logic          rd_en;

  logic [PB-1:0] store_mem [gbn_arq_pkg::MODULUS];

  // input register
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= in_item_i;
    end
  end

  // one-result events
  always_comb begin
    next_d     = next_q;
    oldest_d   = oldest_q;
    expected_d = expected_q;
    count_d    = count_q;
    store_we   = 1'b0;
    single_res = '0;
    single_res.kind = gbn_arq_pkg::KIND_STATUS;
    unique case (in_q.command)
      gbn_arq_pkg::CMD_NET_READY: begin
        if (count_q < SEQ_TOP) begin
          store_we             = cmd_i.exec_single;
          single_res.kind      = gbn_arq_pkg::KIND_DATA;
          single_res.frame_seq = next_q;
          single_res.payload   = in_q.tx_payload;
          count_d              = count_q + 1'b1;
          next_d               = seq_inc(next_q);
        end
      end
      gbn_arq_pkg::CMD_FRAME: begin
        if (in_q.rx_valid) begin
          if (in_q.rx_seq == expected_q) begin
            single_res.kind      = gbn_arq_pkg::KIND_DELIVER;
            single_res.frame_seq = in_q.rx_seq;
            single_res.payload   = in_q.rx_payload;
            expected_d           = seq_inc(expected_q);
            // release everything up to and including rx_ack
            if (in_span(oldest_q, in_q.rx_ack, next_q)) begin
              count_d  = count_q - seq_dist(oldest_q, in_q.rx_ack) - 1'b1;
              oldest_d = seq_inc(in_q.rx_ack);
            end
          end else begin
            single_res.kind      = gbn_arq_pkg::KIND_NAK;
            single_res.frame_seq = in_q.rx_seq;
          end
        end
      end
      gbn_arq_pkg::CMD_TIMEOUT: begin
      end
      gbn_arq_pkg::CMD_CKSUM_ERR: begin
      end
      default: begin
      end
    endcase
    single_res.frame_ack       = ack_of(expected_d);
    single_res.outstanding     = count_d;
    single_res.network_enabled = (count_d < SEQ_TOP);
    single_res.last            = 1'b1;
  end

  always_comb begin
    resend_res                 = '0;
    resend_res.kind            = gbn_arq_pkg::KIND_DATA;
    resend_res.frame_seq       = rd_ptr_q;
    resend_res.frame_ack       = ack_of(expected_q);
    resend_res.payload         = rd_data_q;
    resend_res.outstanding     = count_q;
    resend_res.network_enabled = (count_q < SEQ_TOP);
    resend_res.last            = (left_q == SB'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_q     <= '0;
      oldest_q   <= '0;
      expected_q <= '0;
      count_q    <= '0;
    end else if (cmd_i.exec_single) begin
      next_q     <= next_d;
      oldest_q   <= oldest_d;
      expected_q <= expected_d;
      count_q    <= count_d;
    end
  end

  // resend pointer and remaining count
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_resend) begin
      rd_ptr_q <= oldest_q;
      left_q   <= count_q;
    end else if (cmd_i.emit_resend) begin
      rd_ptr_q <= seq_inc(rd_ptr_q);
      left_q   <= left_q - 1'b1;
    end
  end

  // packet store
  assign rd_en   = cmd_i.start_resend || cmd_i.emit_resend;
  assign rd_addr = cmd_i.start_resend ? oldest_q : seq_inc(rd_ptr_q);

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_mem[next_q] <= in_q.tx_payload;
    end
    if (rd_en) begin
      rd_data_q <= store_mem[rd_addr];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec_single || cmd_i.emit_resend) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec_single) begin
      out_q <= single_res;
    end else if (cmd_i.emit_resend) begin
      out_q <= resend_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign status_o.out_free      = !out_valid_q || out_ready_i;
  assign status_o.resend_needed = (in_q.command == gbn_arq_pkg::CMD_TIMEOUT) && (count_q != '0);
  assign status_o.resend_last   = (left_q == SB'(1));

  // window never overfills
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= SEQ_TOP)
    else $error("outstanding count above window size");

  // count tracks the span between oldest and next
  a_count_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_dist(oldest_q, next_q) == count_q)
    else $error("outstanding count out of step with sequence pointers");

  // an unread result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec_single || cmd_i.emit_resend) |-> (!out_valid_q || out_ready_i))
    else $error("output register loaded while still full");

  // a resend item is only pushed while frames remain
  a_resend_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_resend |-> (left_q != '0))
    else $error("resend past the outstanding frames");

endmodule
`default_nettype wire

FILE: hdl/go_back_n_arq_sender_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// go_back_n_arq_sender_top
// go-back-n sliding-window link endpoint, sender and in-order receiver
// ----------------------------------------------------------------------------
// one event item enters at a time. it is registered in the accept cycle and
// executed once the output register is free, so an item that makes a single
// result item (network ready, frame arrival, checksum error, timeout with
// nothing outstanding) loads the output register and the block is ready
// again in the cycle after. a timeout with n frames outstanding latches the
// item, reads the oldest frame from the packet store, then sends one resent
// frame per cycle while the output register is free, paced by the single
// read port of the store. a stall on the output side holds the sequencer
// until the output register frees up. every result item carries the window
// status after the event and last marks the final item of an event.
// ----------------------------------------------------------------------------
module go_back_n_arq_sender_top (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire gbn_arq_pkg::in_item_t in_item_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output gbn_arq_pkg::out_item_t     out_item_o
);

  // command and status between sequencer and datapath
  gbn_arq_pkg::dp_cmd_t    dp_cmd;
  gbn_arq_pkg::dp_status_t dp_status;

  // sequencer: idle, execute, resend loop
  gbn_arq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  // window pointers, packet store and output register
  gbn_arq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the go-back-n link endpoint
// ----------------------------------------------------------------------------
// a scripted opening covers the idle window, window full, lost and corrupt
// frames, naks, partial and out-of-span acknowledgements, resend bursts and
// sequence wrap. random traffic follows, mostly well-formed: in-order frames
// whose acks fall inside the window, mixed with noise. every accepted event
// is run through a local model of the endpoint and each result item is
// compared field by field against the oldest expected item. both handshake
// sides stall at random, with one stretch of steady flow.
// ----------------------------------------------------------------------------
module tb_top;
  import gbn_arq_pkg::*;

  // random items after the scripted opening, about 470 items in all
  localparam int TRAFFIC_ITEMS = 445;
  localparam int IDLE_PCT      = 29;
  localparam int SETTLE_CYCLES = 16;

  typedef logic [SEQ_BITS-1:0] seq_t;

  // one line of the scripted opening; want is used only where typed is set
  typedef struct {
    in_item_t  ev;
    bit        typed;
    out_item_t want;
  } script_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  // local model of the endpoint state
  seq_t                    tx_next_seq;
  seq_t                    tx_oldest_seq;
  seq_t                    rx_expect_seq;
  logic [SEQ_BITS-1:0]     tx_in_flight;
  logic [PAYLOAD_BITS-1:0] frame_store [MODULUS];

  out_item_t   step_results[$];       // result items of the event on hand
  out_item_t   expected_link_out[$];  // result items still to arrive
  script_row_t script[$];

  // hand-typed expectation for the item being driven
  bit        row_typed;
  out_item_t row_want;

  bit steady_flow;
  int link_errors;
  int events_accepted;
  int results_checked;
  int data_seen, nak_seen, deliver_seen, status_seen;
  int resend_bursts;

  go_back_n_arq_sender_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard limit, several times the slowest legal run
  initial begin
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // model of the endpoint
  // --------------------------------------------------------------------------

  function automatic seq_t seq_after(input seq_t s);
    return (int'(s) == SEQ_MAX) ? seq_t'(0) : seq_t'(s + 1'b1);
  endfunction

  // true when b lies in the circular span [a, c)
  function automatic bit ack_covers(input seq_t a, input seq_t b, input seq_t c);
    return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
  endfunction

  function automatic void predict_link_event(input in_item_t ev);
    out_item_t r;
    seq_t      s;
    seq_t      ack;
    step_results.delete();
    r = '0;
    case (ev.command)
      CMD_NET_READY: begin
        if (int'(tx_in_flight) < SEQ_MAX) begin
          frame_store[tx_next_seq] = ev.tx_payload;
          r.kind      = KIND_DATA;
          r.frame_seq = tx_next_seq;
          r.payload   = ev.tx_payload;
          step_results.push_back(r);
          tx_in_flight = tx_in_flight + 1'b1;
          tx_next_seq  = seq_after(tx_next_seq);
        end
      end
      CMD_FRAME: begin
        if (ev.rx_valid) begin
          if (ev.rx_seq == rx_expect_seq) begin
            r.kind      = KIND_DELIVER;
            r.frame_seq = ev.rx_seq;
            r.payload   = ev.rx_payload;
            step_results.push_back(r);
            rx_expect_seq = seq_after(rx_expect_seq);
            // the piggybacked ack releases frames only inside the window
            while (tx_in_flight != 0 && ack_covers(tx_oldest_seq, ev.rx_ack, tx_next_seq)) begin
              tx_in_flight  = tx_in_flight - 1'b1;
              tx_oldest_seq = seq_after(tx_oldest_seq);
            end
          end else begin
            r.kind      = KIND_NAK;
            r.frame_seq = ev.rx_seq;
            step_results.push_back(r);
          end
        end
      end
      CMD_TIMEOUT: begin
        s = tx_oldest_seq;
        if (tx_in_flight != 0) resend_bursts++;
        for (int c = 0; c < int'(tx_in_flight) && step_results.size() < SEQ_MAX; c++) begin
          r.kind      = KIND_DATA;
          r.frame_seq = s;
          r.payload   = frame_store[s];
          step_results.push_back(r);
          s = seq_after(s);
        end
      end
      default: ;
    endcase

    if (step_results.size() == 0) begin
      r = '0;
      r.kind = KIND_STATUS;
      step_results.push_back(r);
    end

    // window status after the event goes into every result item
    ack = seq_t'((int'(rx_expect_seq) + SEQ_MAX) % MODULUS);
    foreach (step_results[k]) begin
      step_results[k].frame_ack       = ack;
      step_results[k].outstanding     = tx_in_flight;
      step_results[k].network_enabled = (int'(tx_in_flight) < SEQ_MAX);
      step_results[k].last            = (k == step_results.size() - 1);
    end
  endfunction

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t  %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      link_errors++;
    end
  endfunction

  function automatic void compare_result(input out_item_t want, input out_item_t got);
    check_field("kind", 32'(want.kind), 32'(got.kind));
    check_field("frame_seq", 32'(want.frame_seq), 32'(got.frame_seq));
    check_field("frame_ack", 32'(want.frame_ack), 32'(got.frame_ack));
    check_field("payload", 32'(want.payload), 32'(got.payload));
    check_field("outstanding", 32'(want.outstanding), 32'(got.outstanding));
    check_field("network_enabled", 32'(want.network_enabled), 32'(got.network_enabled));
    check_field("last", 32'(want.last), 32'(got.last));
  endfunction

  // results are checked before the event of the same edge is predicted;
  // an event's results never come out in its own accept cycle
  always @(posedge clk_i) begin : link_monitor
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_link_out.size() == 0) begin
          $display("%0t  unexpected result item: %p", $time, out_item_o);
          link_errors++;
        end else begin
          want = expected_link_out.pop_front();
          compare_result(want, out_item_o);
          results_checked++;
          case (want.kind)
            KIND_DATA:    data_seen++;
            KIND_NAK:     nak_seen++;
            KIND_DELIVER: deliver_seen++;
            default:      status_seen++;
          endcase
        end
      end
      if (in_valid_i && in_ready_o) begin
        predict_link_event(in_item_i);
        if (row_typed) begin
          expected_link_out.push_back(row_want);
        end else begin
          foreach (step_results[k]) expected_link_out.push_back(step_results[k]);
        end
        events_accepted++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result side: ready drops at random with a chance of 29 percent, never in steady flow
  // --------------------------------------------------------------------------
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= steady_flow ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------

  function automatic in_item_t mk_event(input logic [1:0] cmd, input logic [31:0] txp,
                                        input logic rxv, input seq_t seq, input seq_t ack,
                                        input logic [31:0] rxp);
    in_item_t ev;
    ev.command    = cmd;
    ev.tx_payload = txp;
    ev.rx_valid   = rxv;
    ev.rx_seq     = seq;
    ev.rx_ack     = ack;
    ev.rx_payload = rxp;
    return ev;
  endfunction

  // single result item of an event, last always set
  function automatic out_item_t mk_result(input logic [1:0] kind, input seq_t seq,
                                          input seq_t ack, input logic [31:0] pay,
                                          input logic [2:0] outst, input logic en);
    out_item_t r;
    r.kind            = kind;
    r.frame_seq       = seq;
    r.frame_ack       = ack;
    r.payload         = pay;
    r.outstanding     = outst;
    r.network_enabled = en;
    r.last            = 1'b1;
    return r;
  endfunction

  function automatic void add_row(input in_item_t ev, input bit typed, input out_item_t want);
    script_row_t row;
    row.ev    = ev;
    row.typed = typed;
    row.want  = want;
    script.push_back(row);
  endfunction

  // called at a falling edge; holds the item until it is taken
  task automatic offer_event(input in_item_t ev);
    while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= ev;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // random event shaped by the model's window so most traffic is well-formed
  function automatic in_item_t draw_link_event();
    in_item_t ev;
    int       pick;
    ev.command    = 2'($urandom_range(0, 3));
    ev.tx_payload = $urandom();
    ev.rx_valid   = 1'($urandom_range(0, 1));
    ev.rx_seq     = seq_t'($urandom_range(0, SEQ_MAX));
    ev.rx_ack     = seq_t'($urandom_range(0, SEQ_MAX));
    ev.rx_payload = $urandom();
    if ($urandom_range(0, 15) == 0) ev.tx_payload = $urandom_range(0, 1) ? '1 : '0;
    if ($urandom_range(0, 15) == 0) ev.rx_payload = $urandom_range(0, 1) ? '1 : '0;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      ev.command = CMD_NET_READY;
    end else if (pick < 70) begin
      // in-order frame, ack mostly inside the outstanding span
      ev.command  = CMD_FRAME;
      ev.rx_valid = 1'b1;
      ev.rx_seq   = rx_expect_seq;
      if (tx_in_flight != 0 && $urandom_range(0, 3) != 0)
        ev.rx_ack = seq_t'((int'(tx_oldest_seq) +
                            $urandom_range(0, int'(tx_in_flight) - 1)) % MODULUS);
    end else if (pick < 78) begin
      ev.command = CMD_TIMEOUT;
    end else if (pick < 86) begin
      ev.command  = CMD_FRAME;
      ev.rx_valid = 1'b1;
    end else if (pick < 92) begin
      ev.command  = CMD_FRAME;
      ev.rx_valid = 1'b0;
    end else begin
      ev.command = CMD_CKSUM_ERR;
    end
    return ev;
  endfunction

  initial begin : stimulus
    in_item_t ev;
    int       traffic;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_item_i     = '0;
    steady_flow   = 1'b0;
    row_typed     = 1'b0;
    row_want      = '0;
    tx_next_seq   = '0;
    tx_oldest_seq = '0;
    rx_expect_seq = '0;
    tx_in_flight  = '0;
    link_errors   = 0;
    events_accepted = 0;
    results_checked = 0;
    data_seen = 0; nak_seen = 0; deliver_seen = 0; status_seen = 0;
    resend_bursts = 0;

    // idle window: corrupt frame, empty timeout, lost frame all give status
    add_row(mk_event(CMD_CKSUM_ERR, '1, 1'b1, 3'd7, 3'd7, '1), 1'b1,
            mk_result(KIND_STATUS, 3'd0, 3'd7, '0, 3'd0, 1'b1));
    add_row(mk_event(CMD_TIMEOUT, '0, 1'b0, 3'd0, 3'd0, '0), 1'b1,
            mk_result(KIND_STATUS, 3'd0, 3'd7, '0, 3'd0, 1'b1));
    add_row(mk_event(CMD_FRAME, '0, 1'b0, 3'd0, 3'd0, '1), 1'b1,
            mk_result(KIND_STATUS, 3'd0, 3'd7, '0, 3'd0, 1'b1));
    // fill the window with extreme and patterned words
    add_row(mk_event(CMD_NET_READY, '1, 1'b0, 3'd0, 3'd0, '0), 1'b1,
            mk_result(KIND_DATA, 3'd0, 3'd7, '1, 3'd1, 1'b1));
    add_row(mk_event(CMD_NET_READY, '0, 1'b1, 3'd7, 3'd7, '1), 1'b1,
            mk_result(KIND_DATA, 3'd1, 3'd7, '0, 3'd2, 1'b1));
    add_row(mk_event(CMD_NET_READY, 32'hA5A5_A5A5, 1'b0, 3'd0, 3'd0, '0), 1'b0, '0);
    add_row(mk_event(CMD_NET_READY, 32'h5A5A_5A5A, 1'b0, 3'd0, 3'd0, '0), 1'b0, '0);
    add_row(mk_event(CMD_NET_READY, 32'h8000_0000, 1'b0, 3'd0, 3'd0, '0), 1'b0, '0);
    add_row(mk_event(CMD_NET_READY, 32'h0000_0001, 1'b0, 3'd0, 3'd0, '0), 1'b0, '0);
    add_row(mk_event(CMD_NET_READY, 32'h1234_5678, 1'b0, 3'd0, 3'd0, '0), 1'b0, '0);
    // window full: the packet is refused
    add_row(mk_event(CMD_NET_READY, 32'hDEAD_BEEF, 1'b0, 3'd0, 3'd0, '0), 1'b1,
            mk_result(KIND_STATUS, 3'd0, 3'd7, '0, 3'd7, 1'b0));
    // full resend burst
    add_row(mk_event(CMD_TIMEOUT, '1, 1'b1, 3'd5, 3'd5, '1), 1'b0, '0);
    // wrong sequence draws a nak
    add_row(mk_event(CMD_FRAME, '0, 1'b1, 3'd7, 3'd3, 32'hCAFE_F00D), 1'b1,
            mk_result(KIND_NAK, 3'd7, 3'd7, '0, 3'd7, 1'b0));
    // partial release, then an ack outside the span, then release the rest
    add_row(mk_event(CMD_FRAME, '0, 1'b1, 3'd0, 3'd2, '1), 1'b0, '0);
    add_row(mk_event(CMD_FRAME, '0, 1'b1, 3'd1, 3'd7, '0), 1'b0, '0);
    add_row(mk_event(CMD_CKSUM_ERR, 32'h0F0F_0F0F, 1'b0, 3'd2, 3'd6, 32'hF0F0_F0F0), 1'b0, '0);
    add_row(mk_event(CMD_FRAME, '0, 1'b1, 3'd2, 3'd6, 32'h0F0F_0F0F), 1'b0, '0);
    add_row(mk_event(CMD_TIMEOUT, '0, 1'b0, 3'd0, 3'd0, '0), 1'b0, '0);
    add_row(mk_event(CMD_FRAME, '0, 1'b1, 3'd3, 3'd0, '0), 1'b0, '0);
    // sequence wrap on the send side, release across the wrap
    add_row(mk_event(CMD_NET_READY, 32'h7777_7777, 1'b0, 3'd0, 3'd0, '0), 1'b0, '0);
    add_row(mk_event(CMD_NET_READY, 32'h0000_FFFF, 1'b0, 3'd0, 3'd0, '0), 1'b0, '0);
    add_row(mk_event(CMD_NET_READY, 32'hFFFF_0000, 1'b0, 3'd0, 3'd0, '0), 1'b0, '0);
    add_row(mk_event(CMD_FRAME, '0, 1'b1, 3'd4, 3'd0, 32'h1357_9BDF), 1'b0, '0);
    add_row(mk_event(CMD_TIMEOUT, '0, 1'b0, 3'd0, 3'd0, '0), 1'b0, '0);
    add_row(mk_event(CMD_FRAME, '0, 1'b0, 3'd5, 3'd1, '1), 1'b0, '0);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // scripted opening
    foreach (script[i]) begin
      @(negedge clk_i);
      row_typed = script[i].typed;
      row_want  = script[i].want;
      offer_event(script[i].ev);
    end

    // random traffic, every item counted
    traffic = 0;
    while (traffic < TRAFFIC_ITEMS) begin
      @(negedge clk_i);
      steady_flow = (traffic >= 200 && traffic < 280);
      // now and then let everything drain before the next item
      if (traffic == 150 || $urandom_range(0, 99) == 0) begin
        while (expected_link_out.size() != 0) begin
          in_valid_i <= 1'b0;
          @(negedge clk_i);
        end
      end
      row_typed = 1'b0;
      ev = draw_link_event();
      offer_event(ev);
      traffic++;
    end

    @(negedge clk_i);
    in_valid_i  <= 1'b0;
    steady_flow = 1'b0;
    while (expected_link_out.size() != 0) @(posedge clk_i);
    // watch for stray result items after the last one due
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_link_out.size() != 0) begin
      $display("%0t  %0d result items never arrived", $time, expected_link_out.size());
      link_errors++;
    end

    $display("covered %0d events, %0d of them timeouts with frames to resend",
             events_accepted, resend_bursts);
    $display("checked %0d result items: %0d data, %0d nak, %0d delivered, %0d status",
             results_checked, data_seen, nak_seen, deliver_seen, status_seen);
    if (link_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
